/* rtl/core/first_fit_resource_map_top_defines.svh */
// Assertion macros shared by the block's checkers.
`ifndef FIRST_FIT_RESOURCE_MAP_TOP_DEFINES_SVH
`define FIRST_FIT_RESOURCE_MAP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define FFRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FFRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks across reset.
`define FFRM_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ffrm_pkg.sv */
package ffrm_pkg;

    localparam int MAP_ENTRIES_DEF = 32;
    localparam int ADDR_BITS_DEF   = 16;
    localparam int LEN_BITS        = 16;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    // shared unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] req_size;
        logic [15:0] req_addr;
    } t_in_item;

    typedef struct packed {
        logic [15:0] base_addr;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic ge;   // a >= b on subtract
        logic eq;   // result equals compare operand
    } t_alu_flags;

endpackage

/* rtl/core/ffrm_alu.sv */
module ffrm_alu #(
    parameter int AW = 16
) (
    input  logic          i_op,
    input  logic [AW-1:0] i_a,
    input  logic [AW-1:0] i_b,
    input  logic [AW-1:0] i_c,
    output logic [AW:0]   o_res,
    output ffrm_pkg::t_alu_flags o_flags
);
    import ffrm_pkg::*;

    always_comb begin
        if (i_op == ALU_SUB) begin
            o_res = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            o_res = {1'b0, i_a} + {1'b0, i_b};
        end
        o_flags.ge = ~o_res[AW];
        o_flags.eq = (o_res == {1'b0, i_c});
    end

endmodule

/* rtl/core/ffrm_table.sv */
module ffrm_table #(
    parameter int ENTRIES   = 32,
    parameter int ADDR_BITS = 16,
    parameter int LEN_BITS  = 16,
    localparam int IW       = $clog2(ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [IW-1:0]        i_rd_addr,
    output logic [ADDR_BITS-1:0] o_rd_base,
    output logic [LEN_BITS-1:0]  o_rd_len,
    input  logic                 i_wr_en,
    input  logic [IW-1:0]        i_wr_addr,
    input  logic [ADDR_BITS-1:0] i_wr_base,
    input  logic [LEN_BITS-1:0]  i_wr_len
);
    logic [ADDR_BITS+LEN_BITS-1:0] mem [ENTRIES];
    logic [ADDR_BITS+LEN_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_base, i_wr_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_base = r_rd_data[ADDR_BITS+LEN_BITS-1:LEN_BITS];
    assign o_rd_len  = r_rd_data[LEN_BITS-1:0];

endmodule

/* rtl/core/first_fit_resource_map_top.sv */
// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_ready     i_in_data  (mode, req_size, req_addr)
// result    out        o_out_valid / i_out_ready   o_out_data (base_addr, status)
//
// One request at a time; o_in_ready is high only while the sequencer is idle.
// Allocate scans up to the first hit at entry i and removes it by a shift of
// count - i entries when it is used up; free scans up to pos, then shifts the
// entries from pos upward when it inserts or bridges. Time is set by the single table port
// and the one shared add/compare unit that the scan and merge steps go through.
// Synchronous active-low reset empties the map at once; no clearing pass.
// A finished result waits in the output register; a new request may be taken
// while it waits, and only the next completion stalls on it.
module first_fit_resource_map_top #(
    parameter int MAP_ENTRIES = ffrm_pkg::MAP_ENTRIES_DEF,
    parameter int ADDR_BITS   = ffrm_pkg::ADDR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffrm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffrm_pkg::t_out_item o_out_data
);
    import ffrm_pkg::*;

    localparam int IW = $clog2(MAP_ENTRIES);
    localparam int CW = $clog2(MAP_ENTRIES + 1);
    localparam int AW = (ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_AUPD    = 4'd2;
    localparam logic [3:0] S_FPREV   = 4'd3;
    localparam logic [3:0] S_FNEXT   = 4'd4;
    localparam logic [3:0] S_FMRG1   = 4'd5;
    localparam logic [3:0] S_FMRG2   = 4'd6;
    localparam logic [3:0] S_SDSTART = 4'd7;
    localparam logic [3:0] S_SDMOVE  = 4'd8;
    localparam logic [3:0] S_SUSTART = 4'd9;
    localparam logic [3:0] S_SUMOVE  = 4'd10;
    localparam logic [3:0] S_SUINS   = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0]           r_state, n_state;
    logic                 r_mode, n_mode;
    logic [LEN_BITS-1:0]  r_size, n_size;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_pos, n_pos;
    logic [CW-1:0]        r_count, n_count;
    logic [ADDR_BITS-1:0] r_prev_base, n_prev_base;
    logic [LEN_BITS-1:0]  r_prev_len, n_prev_len;
    logic                 r_have_prev, n_have_prev;
    logic [ADDR_BITS-1:0] r_nxt_base, n_nxt_base;
    logic [LEN_BITS-1:0]  r_nxt_len, n_nxt_len;
    logic                 r_has_nxt, n_has_nxt;
    logic [LEN_BITS-1:0]  r_rem, n_rem;
    logic [LEN_BITS-1:0]  r_acc, n_acc;
    logic                 r_mprev, n_mprev;
    logic                 r_mnext, n_mnext;
    logic [15:0]          r_res_base, n_res_base;
    logic [1:0]           r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    // table port
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [ADDR_BITS-1:0] rd_base;
    logic [LEN_BITS-1:0]  rd_len;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [ADDR_BITS-1:0] wr_base;
    logic [LEN_BITS-1:0]  wr_len;

    // shared unit
    logic                 alu_op;
    logic [AW-1:0]        alu_a, alu_b, alu_c;
    logic [AW:0]          alu_res;
    t_alu_flags           alu_flags;
    logic [LEN_BITS-1:0]  alu_sat;

    // counter helpers, one bit wider so that count + 1 cannot wrap
    logic [CW:0]          idx_p1, idx_p2, idx_m1, idx_m2, count_w;

    ffrm_table #(
        .ENTRIES   (MAP_ENTRIES),
        .ADDR_BITS (ADDR_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_base (rd_base),
        .o_rd_len  (rd_len),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_base (wr_base),
        .i_wr_len  (wr_len)
    );

    ffrm_alu #(
        .AW (AW)
    ) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_c     (alu_c),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    // Clamp a merged length at the largest extent size.
    assign alu_sat = (|alu_res[AW:LEN_BITS]) ? LEN_MAX : alu_res[LEN_BITS-1:0];

    assign idx_p1  = {1'b0, r_idx} + (CW+1)'(1);
    assign idx_p2  = {1'b0, r_idx} + (CW+1)'(2);
    assign idx_m1  = {1'b0, r_idx} - (CW+1)'(1);
    assign idx_m2  = {1'b0, r_idx} - (CW+1)'(2);
    assign count_w = {1'b0, r_count};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_size       = r_size;
        n_addr       = r_addr;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_count      = r_count;
        n_prev_base  = r_prev_base;
        n_prev_len   = r_prev_len;
        n_have_prev  = r_have_prev;
        n_nxt_base   = r_nxt_base;
        n_nxt_len    = r_nxt_len;
        n_has_nxt    = r_has_nxt;
        n_rem        = r_rem;
        n_acc        = r_acc;
        n_mprev      = r_mprev;
        n_mnext      = r_mnext;
        n_res_base   = r_res_base;
        n_res_status = r_res_status;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;

        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_base = '0;
        wr_len  = '0;
        alu_op  = ALU_ADD;
        alu_a   = '0;
        alu_b   = '0;
        alu_c   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // Latch the request and start reading entry 0.
                    n_mode       = i_in_data.mode;
                    n_size       = i_in_data.req_size;
                    n_addr       = ADDR_BITS'(i_in_data.req_addr);
                    n_idx        = '0;
                    n_have_prev  = 1'b0;
                    n_has_nxt    = 1'b0;
                    n_res_base   = '0;
                    n_res_status = ST_OK;
                    rd_en        = 1'b1;
                    rd_addr      = '0;
                    n_state      = S_SCAN;
                end
            end

            S_SCAN: begin
                // Read data holds the entry at r_idx.
                if (r_idx == r_count) begin
                    if (r_mode == MODE_ALLOC) begin
                        n_res_status = ST_NO_SPACE;
                        n_state      = S_DONE;
                    end else begin
                        n_pos   = r_idx;
                        n_state = S_FPREV;
                    end
                end else if (r_mode == MODE_ALLOC) begin
                    alu_op = ALU_SUB;
                    alu_a  = AW'(rd_len);
                    alu_b  = AW'(r_size);
                    if (alu_flags.ge) begin
                        n_nxt_base = rd_base;
                        n_rem      = alu_res[LEN_BITS-1:0];
                        n_res_base = 16'(rd_base);
                        n_state    = S_AUPD;
                    end else begin
                        n_idx   = idx_p1[CW-1:0];
                        rd_en   = (idx_p1 < count_w);
                        rd_addr = idx_p1[IW-1:0];
                    end
                end else begin
                    alu_op = ALU_SUB;
                    alu_a  = AW'(r_addr);
                    alu_b  = AW'(rd_base);
                    if (alu_flags.ge) begin
                        n_prev_base = rd_base;
                        n_prev_len  = rd_len;
                        n_have_prev = 1'b1;
                        n_idx       = idx_p1[CW-1:0];
                        rd_en       = (idx_p1 < count_w);
                        rd_addr     = idx_p1[IW-1:0];
                    end else begin
                        n_pos      = r_idx;
                        n_nxt_base = rd_base;
                        n_nxt_len  = rd_len;
                        n_has_nxt  = 1'b1;
                        n_state    = S_FPREV;
                    end
                end
            end

            S_AUPD: begin
                if (r_rem == '0) begin
                    n_state = S_SDSTART;
                end else begin
                    // Advance the base with wrap and keep the remainder.
                    alu_a   = AW'(r_nxt_base);
                    alu_b   = AW'(r_size);
                    wr_en   = 1'b1;
                    wr_addr = r_idx[IW-1:0];
                    wr_base = alu_res[ADDR_BITS-1:0];
                    wr_len  = r_rem;
                    n_state = S_DONE;
                end
            end

            S_FPREV: begin
                alu_a   = AW'(r_prev_base);
                alu_b   = AW'(r_prev_len);
                alu_c   = AW'(r_addr);
                n_mprev = r_have_prev && alu_flags.eq;
                n_state = S_FNEXT;
            end

            S_FNEXT: begin
                alu_a   = AW'(r_addr);
                alu_b   = AW'(r_size);
                alu_c   = AW'(r_nxt_base);
                n_mnext = r_has_nxt && alu_flags.eq;
                n_state = S_FMRG1;
            end

            S_FMRG1: begin
                if (r_mprev) begin
                    alu_a   = AW'(r_prev_len);
                    alu_b   = AW'(r_size);
                    n_acc   = alu_sat;
                    n_state = S_FMRG2;
                end else if (r_mnext) begin
                    // Grow the next extent downward.
                    alu_a   = AW'(r_nxt_len);
                    alu_b   = AW'(r_size);
                    wr_en   = 1'b1;
                    wr_addr = r_pos[IW-1:0];
                    wr_base = r_addr;
                    wr_len  = alu_sat;
                    n_state = S_DONE;
                end else if (r_size == '0) begin
                    n_state = S_DONE;
                end else if (r_count == CW'(MAP_ENTRIES)) begin
                    n_res_status = ST_TABLE_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = r_count;
                    n_state = S_SUSTART;
                end
            end

            S_FMRG2: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[IW-1:0] - IW'(1);
                wr_base = r_prev_base;
                if (r_mnext) begin
                    // Bridge both neighbors, then drop the upper one.
                    alu_a   = AW'(r_acc);
                    alu_b   = AW'(r_nxt_len);
                    wr_len  = alu_sat;
                    n_idx   = r_pos;
                    n_state = S_SDSTART;
                end else begin
                    wr_len  = r_acc;
                    n_state = S_DONE;
                end
            end

            S_SDSTART: begin
                if (idx_p1 >= count_w) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_p1[IW-1:0];
                    n_state = S_SDMOVE;
                end
            end

            S_SDMOVE: begin
                // Move entry r_idx + 1 down to r_idx.
                wr_en   = 1'b1;
                wr_addr = r_idx[IW-1:0];
                wr_base = rd_base;
                wr_len  = rd_len;
                n_idx   = idx_p1[CW-1:0];
                if (idx_p2 < count_w) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_p2[IW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_SUSTART: begin
                if (r_idx == r_pos) begin
                    n_state = S_SUINS;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_m1[IW-1:0];
                    n_state = S_SUMOVE;
                end
            end

            S_SUMOVE: begin
                // Move entry r_idx - 1 up to r_idx.
                wr_en   = 1'b1;
                wr_addr = r_idx[IW-1:0];
                wr_base = rd_base;
                wr_len  = rd_len;
                n_idx   = idx_m1[CW-1:0];
                if (idx_m1[CW-1:0] != r_pos) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_m2[IW-1:0];
                end else begin
                    n_state = S_SUINS;
                end
            end

            S_SUINS: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[IW-1:0];
                wr_base = r_addr;
                wr_len  = r_size;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out.base_addr = r_res_base;
                    n_out.status    = r_res_status;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_size       <= n_size;
        r_addr       <= n_addr;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_prev_base  <= n_prev_base;
        r_prev_len   <= n_prev_len;
        r_have_prev  <= n_have_prev;
        r_nxt_base   <= n_nxt_base;
        r_nxt_len    <= n_nxt_len;
        r_has_nxt    <= n_has_nxt;
        r_rem        <= n_rem;
        r_acc        <= n_acc;
        r_mprev      <= n_mprev;
        r_mnext      <= n_mnext;
        r_res_base   <= n_res_base;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

endmodule

/* rtl/core/ffrm_chk.sv */
`include "first_fit_resource_map_top_defines.svh"

module ffrm_chk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ffrm_pkg::t_out_item i_out_data
);
    import ffrm_pkg::*;

    // Reset leaves the block idle with no result pending.
    `FFRM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, i_in_ready && !i_out_valid, "not idle after reset")

    // One request in flight: ready drops after each transfer.
    `FFRM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready held after request transfer")

    // Failed allocate and table-full free both report base zero.
    `FFRM_ASSERT_NOW(a_fail_base_zero, i_clk, i_rst_n, i_out_valid && (i_out_data.status != ST_OK), i_out_data.base_addr == '0, "nonzero base on failure")

    // A stalled result holds.
    `FFRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")

endmodule

bind first_fit_resource_map_top ffrm_chk u_ffrm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

/* tb/sv/first_fit_resource_map_top_tb.sv */
`timescale 1ns / 100ps

module first_fit_resource_map_top_tb;
    import ffrm_pkg::*;

    localparam int MAP_ENTRIES  = MAP_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1500;
    // Generous bound on the whole run, idling included.
    localparam int CYCLE_LIMIT  = 1000000;
    // Settling time after the last result, sized from the worst request latency.
    localparam int DRAIN_CYCLES = 4 * MAP_ENTRIES_DEF + 64;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    t_in_item  req_data  = '0;
    logic      res_ready = 1'b0;
    logic      req_ready;
    logic      res_valid;
    t_out_item res_data;

    // Requests not yet offered, and results owed by the block in transfer order.
    t_in_item  pending_reqs[$];
    t_out_item owed_results[$];

    int total_items    = 0;
    int accepted_count = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    // Shadow copy of the free-extent table.
    logic [15:0] extent_base[MAP_ENTRIES];
    logic [15:0] extent_len[MAP_ENTRIES];
    int          extent_count = 0;

    first_fit_resource_map_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_ready (req_ready),
        .i_in_data  (req_data),
        .o_out_valid(res_valid),
        .i_out_ready(res_ready),
        .o_out_data (res_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] sat_len_sum(logic [15:0] a, logic [15:0] b);
        logic [16:0] sum;
        sum = a + b;
        return sum[16] ? LEN_MAX : sum[15:0];
    endfunction

    // Remove one extent and close the gap.
    function automatic void drop_extent(int pos);
        for (int k = pos; k + 1 < extent_count; k++) begin
            extent_base[k] = extent_base[k + 1];
            extent_len[k]  = extent_len[k + 1];
        end
        if (extent_count > 0) begin
            extent_count--;
            extent_base[extent_count] = '0;
            extent_len[extent_count]  = '0;
        end
    endfunction

    // Apply one request to the shadow table and return the grant it should produce.
    function automatic t_out_item predict_grant(t_in_item req);
        t_out_item   res;
        logic [15:0] sz;
        logic [15:0] addr;
        logic [16:0] end_sum;
        logic        hit;
        int          pos;
        sz             = req.req_size;
        addr           = req.req_addr;
        end_sum        = addr + sz;
        res.base_addr  = '0;
        res.status     = ST_OK;
        if (req.mode == MODE_ALLOC) begin
            res.status = ST_NO_SPACE;
            hit        = 1'b0;
            for (int k = 0; k < extent_count && !hit; k++) begin
                if (extent_len[k] >= sz) begin
                    hit            = 1'b1;
                    res.base_addr  = extent_base[k];
                    res.status     = ST_OK;
                    extent_base[k] = extent_base[k] + sz;
                    extent_len[k]  = extent_len[k] - sz;
                    if (extent_len[k] == '0)
                        drop_extent(k);
                end
            end
        end else begin
            pos = 0;
            while (pos < extent_count && extent_base[pos] <= addr)
                pos++;
            if (pos > 0 &&
                ({1'b0, extent_base[pos - 1]} + extent_len[pos - 1]) == {1'b0, addr}) begin
                extent_len[pos - 1] = sat_len_sum(extent_len[pos - 1], sz);
                if (pos < extent_count && end_sum == {1'b0, extent_base[pos]}) begin
                    extent_len[pos - 1] = sat_len_sum(extent_len[pos - 1], extent_len[pos]);
                    drop_extent(pos);
                end
            end else if (pos < extent_count && end_sum == {1'b0, extent_base[pos]}) begin
                extent_base[pos] = addr;
                extent_len[pos]  = sat_len_sum(extent_len[pos], sz);
            end else if (sz == '0) begin
                res.status = ST_OK;
            end else if (extent_count >= MAP_ENTRIES) begin
                res.status = ST_TABLE_FULL;
            end else begin
                for (int k = extent_count; k > pos; k--) begin
                    extent_base[k] = extent_base[k - 1];
                    extent_len[k]  = extent_len[k - 1];
                end
                extent_base[pos] = addr;
                extent_len[pos]  = sz;
                extent_count++;
            end
        end
        return res;
    endfunction

    function automatic void queue_request(logic mode, int unsigned sz, int unsigned addr);
        t_in_item item;
        item.mode     = mode;
        item.req_size = sz[15:0];
        item.req_addr = addr[15:0];
        pending_reqs.push_back(item);
        total_items++;
    endfunction

    // Idle profile, stepped through as requests are taken:
    // none, sender idle, receiver stall, both.
    function automatic int idle_phase();
        if (total_items == 0)
            return 0;
        return (accepted_count * 4) / total_items;
    endfunction

    function automatic bit sender_holds();
        int ph;
        ph = idle_phase();
        if (ph == 1)
            return $urandom_range(99) < 68;
        if (ph == 3)
            return $urandom_range(99) < 23;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        int ph;
        ph = idle_phase();
        if (ph == 2)
            return $urandom_range(99) < 68;
        if (ph == 3)
            return $urandom_range(99) < 23;
        return 1'b0;
    endfunction

    // Request driver: hold valid and payload until the transfer, then advance.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req_ready) begin
                owed_results.push_back(predict_grant(req_data));
                accepted_count++;
            end
            if (!req_valid || req_ready) begin
                if (pending_reqs.size() != 0 && !sender_holds()) begin
                    req_valid <= 1'b1;
                    req_data  <= pending_reqs.pop_front();
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check every transfer against the oldest owed result.
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result base_addr %h status %0d",
                             $time, res_data.base_addr, res_data.status);
                    err_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (res_data.base_addr !== want.base_addr) begin
                        $display("%0t: base_addr mismatch, expected %h actual %h",
                                 $time, want.base_addr, res_data.base_addr);
                        err_count++;
                    end
                    if (res_data.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, res_data.status);
                        err_count++;
                    end
                end
            end
            res_ready <= !receiver_stalls();
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("first_fit_resource_map_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int unsigned pick;
        int unsigned run_addr;
        int unsigned cursor;
        int unsigned sz;
        int unsigned stride;
        int unsigned n;
        int unsigned j;
        int unsigned tmp;
        int unsigned piece_addr[6];
        int unsigned piece_size[6];

        // Directed: empty map, size-zero requests, every merge kind, saturation,
        // an extent ending at the top of the address space, exact removal.
        queue_request(MODE_ALLOC, 0, 16'h0000);          // empty map, size zero
        queue_request(MODE_ALLOC, 16'hFFFF, 16'hFFFF);   // empty map, largest size
        queue_request(MODE_FREE, 0, 16'h1000);           // size zero, nothing to touch
        queue_request(MODE_FREE, 16'h0100, 16'h1000);    // first insert
        queue_request(MODE_FREE, 0, 16'h1100);           // size zero touching previous end
        queue_request(MODE_FREE, 16'h0080, 16'h1100);    // merge with previous
        queue_request(MODE_FREE, 16'h0100, 16'h0F00);    // merge with next
        queue_request(MODE_FREE, 16'h0040, 16'h2000);    // insert after
        queue_request(MODE_FREE, 16'h0E80, 16'h1180);    // bridge previous and next
        queue_request(MODE_FREE, 16'h8000, 16'h4000);    // insert
        queue_request(MODE_FREE, 16'h9000, 16'hC000);    // merged length saturates
        queue_request(MODE_ALLOC, 0, 16'hFFFF);          // size zero takes first extent
        queue_request(MODE_ALLOC, 16'h0010, 16'h0000);   // partial take
        queue_request(MODE_ALLOC, 16'hFFFF, 16'h0000);   // exact fit of the saturated extent, removed
        queue_request(MODE_ALLOC, 16'hD000, 16'h0000);   // too big, no space
        queue_request(MODE_FREE, 16'h0100, 16'hFF00);    // ends exactly at the top
        queue_request(MODE_FREE, 16'h0010, 16'h0000);    // address zero, no wrap merge
        queue_request(MODE_ALLOC, 16'h0010, 16'h1234);   // exact fit, extent removed
        queue_request(MODE_FREE, 16'hFFFF, 16'hFFFF);    // largest fields
        queue_request(MODE_FREE, 16'h0010, 16'h1000);    // overlaps an extent
        queue_request(MODE_FREE, 0, 16'h7777);           // size zero, no merge

        while (total_items < 21 + RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                // Free one contiguous run in shuffled pieces to hit every merge path.
                run_addr = $urandom_range(16'hFFFF) & 16'hFFF0;
                n        = $urandom_range(6, 2);
                cursor   = run_addr;
                for (int k = 0; k < n; k++) begin
                    piece_size[k] = $urandom_range(32, 1);
                    piece_addr[k] = cursor;
                    cursor        = cursor + piece_size[k];
                end
                for (int k = n - 1; k > 0; k--) begin
                    j             = $urandom_range(k);
                    tmp           = piece_addr[k];
                    piece_addr[k] = piece_addr[j];
                    piece_addr[j] = tmp;
                    tmp           = piece_size[k];
                    piece_size[k] = piece_size[j];
                    piece_size[j] = tmp;
                end
                for (int k = 0; k < n; k++) begin
                    queue_request(MODE_FREE, piece_size[k], piece_addr[k]);
                    if ($urandom_range(99) < 30)
                        queue_request(MODE_ALLOC, $urandom_range(48), $urandom);
                end
            end else if (pick < 43) begin
                // Scatter spaced frees until the table overflows.
                sz       = $urandom_range(8, 1);
                stride   = 2 * sz + $urandom_range(4);
                run_addr = $urandom_range(16'hFFFF);
                n        = $urandom_range(36, 33);
                for (int k = 0; k < n; k++)
                    queue_request(MODE_FREE, sz, run_addr + k * stride);
            end else if (pick < 65) begin
                // Drain with mostly small allocations.
                n = $urandom_range(30, 10);
                for (int k = 0; k < n; k++) begin
                    tmp = $urandom_range(99);
                    if (tmp < 55)
                        sz = $urandom_range(16);
                    else if (tmp < 85)
                        sz = $urandom_range(256);
                    else if (tmp < 95)
                        sz = $urandom_range(16'hFFFF);
                    else
                        sz = 16'hFFFF;
                    queue_request(MODE_ALLOC, sz, $urandom);
                end
            end else if (pick < 80) begin
                // Unshaped traffic.
                n = $urandom_range(15, 5);
                for (int k = 0; k < n; k++)
                    queue_request(1'($urandom_range(1)), $urandom_range(16'hFFFF),
                                  $urandom_range(16'hFFFF));
            end else begin
                // Top of the address space, size zero and extreme sizes.
                n = $urandom_range(10, 4);
                for (int k = 0; k < n; k++) begin
                    case ($urandom_range(3))
                        0: queue_request(MODE_FREE, $urandom_range(1024),
                                         16'hFF00 | $urandom_range(255));
                        1: queue_request(MODE_FREE, 0, $urandom_range(16'hFFFF));
                        2: queue_request(MODE_ALLOC, 0, $urandom);
                        default: queue_request(MODE_ALLOC, $urandom_range(16'hFFFF, 16'hF000),
                                               $urandom);
                    endcase
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sample away from the active edge so the driver and monitor have settled.
        do
            @(negedge clk);
        while (accepted_count != total_items || owed_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("first_fit_resource_map_top_tb: done, clean");
        else
            $display("first_fit_resource_map_top_tb: done, errors");
        $finish;
    end

endmodule
